FILE: hw/rtl/ibt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_pkg
// shared types and constants of the ip ban table
// ----------------------------------------------------------------------------
package ibt_pkg;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    localparam logic [5:0]  SECONDS_PER_MINUTE = 6'd60;
    localparam logic [31:0] MAX_EXPIRY         = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        valid;
        logic [31:0] expiry;
        logic [31:0] address;
    } entry_t;

endpackage

FILE: hw/rtl/ibt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_mem
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ibt_mem
    import ibt_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  entry_t             wr_data,
    input  logic [IDX_W-1:0]   rd_addr,
    output entry_t             rd_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/ibt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_ctrl
// clearing pass, per-transaction entry scan and result register
// ----------------------------------------------------------------------------
module ibt_ctrl
    import ibt_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [31:0]        ip_address,
    input  logic [15:0]        ban_minutes,
    input  logic [31:0]        now_seconds,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               banned,
    output logic               stored,
    output logic               wr_en,
    output logic [IDX_W-1:0]   wr_addr,
    output entry_t             wr_data,
    output logic [IDX_W-1:0]   rd_addr,
    input  entry_t             rd_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             banned_acc_reg, banned_acc_next;
    logic             stored_acc_reg, stored_acc_next;
    logic             out_valid_reg, out_valid_next;
    logic             banned_reg, banned_next;
    logic             stored_reg, stored_next;

    logic             cmd_reg;
    logic [31:0]      address_reg;
    logic [15:0]      minutes_reg;
    logic [31:0]      now_reg;

    logic             accept;
    logic             last;
    logic             live;
    logic             expired;
    logic [21:0]      ban_secs;
    logic [32:0]      expiry_sum;
    logic [31:0]      expiry_new;

    assign accept = in_valid && !in_stall;
    assign last   = (idx_reg == LAST_IDX);

    assign ban_secs   = 22'(minutes_reg) * 22'(SECONDS_PER_MINUTE);
    assign expiry_sum = {1'b0, now_reg} + 33'(ban_secs);
    assign expiry_new = expiry_sum[32] ? MAX_EXPIRY : expiry_sum[31:0];

    assign expired = rd_data.valid && (rd_data.expiry < now_reg);
    assign live    = rd_data.valid && !(rd_data.expiry < now_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        banned_acc_next = banned_acc_reg;
        stored_acc_next = stored_acc_reg;
        out_valid_next  = out_valid_reg;
        banned_next     = banned_reg;
        stored_next     = stored_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = '0;
        rd_addr         = '0;
        in_stall        = (state_reg != ST_IDLE);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (last)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next        = '0;
                    banned_acc_next = 1'b0;
                    stored_acc_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_addr = last ? '0 : idx_reg + 1'b1;
                if (cmd_reg == CMD_ADD)
                begin
                    if (!live)
                    begin
                        wr_en           = 1'b1;
                        wr_data.valid   = 1'b1;
                        wr_data.expiry  = expiry_new;
                        wr_data.address = address_reg;
                        stored_acc_next = 1'b1;
                        state_next      = ST_DONE;
                    end
                    else if (last)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    if (expired)
                    begin
                        // prune: drop the valid mark, keep the rest of the word
                        wr_en         = 1'b1;
                        wr_data       = rd_data;
                        wr_data.valid = 1'b0;
                    end
                    else if (live && (rd_data.address == address_reg))
                    begin
                        banned_acc_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_DONE;
                    end
                end
                if (!last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    banned_next    = banned_acc_reg;
                    stored_next    = stored_acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            banned_acc_reg <= 1'b0;
            stored_acc_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            banned_reg     <= 1'b0;
            stored_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            banned_acc_reg <= banned_acc_next;
            stored_acc_reg <= stored_acc_next;
            out_valid_reg  <= out_valid_next;
            banned_reg     <= banned_next;
            stored_reg     <= stored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= command;
            address_reg <= ip_address;
            minutes_reg <= ban_minutes;
            now_reg     <= now_seconds;
        end
    end

    assign out_valid = out_valid_reg;
    assign banned    = banned_reg;
    assign stored    = stored_reg;

`ifndef SYNTHESIS
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(banned && stored))
        else $error("banned and stored both set");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("transaction accepted while scan in progress");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("memory write outside clear or scan");

    a_add_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg == ST_SCAN) && (cmd_reg == CMD_ADD)) |=> !wr_en)
        else $error("add wrote more than one slot");
`endif

endmodule

FILE: hw/rtl/ip_ban_table_with_expiry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_ban_table_with_expiry
// table of banned ipv4 addresses with absolute expiry times
// ----------------------------------------------------------------------------
// Each transaction scans the entry memory one word per cycle through its
// single read port. A check always visits all ENTRIES words; an add stops
// at the first free or expired slot. One transaction is worked on at a
// time; a finished result waits in the output register while the next one
// is accepted. After reset a clearing pass writes every word invalid, and
// no transaction is accepted during it.
// ----------------------------------------------------------------------------
module ip_ban_table_with_expiry
    import ibt_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] ip_address,
    input  logic [15:0] ban_minutes,
    input  logic [31:0] now_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        banned,
    output logic        stored
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    ibt_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .ip_address  (ip_address),
        .ban_minutes (ban_minutes),
        .now_seconds (now_seconds),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .banned      (banned),
        .stored      (stored),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    ibt_mem #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

FILE: tb/tb_ip_ban_table_with_expiry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ip_ban_table_with_expiry
// self-checking bench for the ip ban table with expiry
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the ban table. Each accepted
// transaction updates it and queues the expected banned and stored flags,
// and each result from the block is checked against the oldest entry.
// A short directed run covers zero-length bans, pruning, expiry saturation
// and a full table. Random traffic then mixes adds and checks on a small
// address pool with a drifting clock, bursts of adds that fill the table
// and jumps in time. Both sides idle at random; the receiver holds off once
// for a long stretch, and the sender pauses until all results are checked.
// ----------------------------------------------------------------------------
module tb_ip_ban_table_with_expiry;

    import ibt_pkg::*;

    localparam int TABLE_SIZE  = 16;
    localparam int POOL_SIZE   = 8;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic banned;
        logic stored;
    } verdict_t;

    class ban_scoreboard;
        bit          slot_used [TABLE_SIZE];
        logic [31:0] slot_ip   [TABLE_SIZE];
        logic [31:0] slot_until[TABLE_SIZE];
        verdict_t    pending_verdicts[$];
        int          errors;

        function new();
            foreach (slot_used[i])
            begin
                slot_used[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        function void note_input(logic cmd, logic [31:0] ip, logic [15:0] mins,
                                 logic [31:0] now);
            verdict_t    v;
            logic [32:0] sum;
            logic [31:0] until_s;
            v.banned = 1'b0;
            v.stored = 1'b0;
            if (cmd == CMD_ADD)
            begin
                sum     = {1'b0, now} + 33'(mins) * 33'(SECONDS_PER_MINUTE);
                until_s = sum[32] ? MAX_EXPIRY : sum[31:0];
                for (int i = 0; i < TABLE_SIZE && !v.stored; i++)
                begin
                    if (!slot_used[i] || slot_until[i] < now)
                    begin
                        slot_used[i]  = 1'b1;
                        slot_ip[i]    = ip;
                        slot_until[i] = until_s;
                        v.stored      = 1'b1;
                    end
                end
            end
            else
            begin
                for (int i = 0; i < TABLE_SIZE; i++)
                begin
                    if (slot_used[i])
                    begin
                        if (slot_until[i] < now)
                            slot_used[i] = 1'b0;
                        else if (slot_ip[i] == ip)
                            v.banned = 1'b1;
                    end
                end
            end
            pending_verdicts.push_back(v);
        endfunction

        function void check_result(logic banned_got, logic stored_got);
            verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result banned=%0b stored=%0b",
                         $time, banned_got, stored_got);
                errors++;
                return;
            end
            v = pending_verdicts.pop_front();
            if (banned_got !== v.banned)
            begin
                $display("%0t: banned expected %0b actual %0b", $time, v.banned, banned_got);
                errors++;
            end
            if (stored_got !== v.stored)
            begin
                $display("%0t: stored expected %0b actual %0b", $time, v.stored, stored_got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [31:0] ip_address;
    logic [15:0] ban_minutes;
    logic [31:0] now_seconds;
    logic        out_valid;
    logic        out_stall;
    logic        banned;
    logic        stored;

    ban_scoreboard ban_table;

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_go;
    logic        hold_active;
    logic [31:0] addr_pool[POOL_SIZE];
    logic [31:0] clock_base;
    int          burst_left;
    logic [15:0] burst_mins;

    ip_ban_table_with_expiry #(
        .ENTRIES (TABLE_SIZE)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .ip_address  (ip_address),
        .ban_minutes (ban_minutes),
        .now_seconds (now_seconds),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .banned      (banned),
        .stored      (stored)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic offer_item(input logic cmd, input logic [31:0] ip,
                              input logic [15:0] mins, input logic [31:0] now);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        ip_address  <= ip;
        ban_minutes <= mins;
        now_seconds <= now;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        ban_table.note_input(cmd, ip, mins, now);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (ban_table.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic offer_random(input int count, input int hold_at, input int pause_at);
        logic        cmd;
        logic [31:0] ip;
        logic [15:0] mins;
        int          r;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
                hold_go = 1'b1;
            if (n == pause_at)
                wait_drained();
            if (burst_left == 0 && $urandom_range(0, 99) < 3)
            begin
                burst_left = $urandom_range(12, 20);
                burst_mins = 16'($urandom_range(1, 65535));
            end
            if (burst_left > 0)
            begin
                burst_left--;
                cmd  = CMD_ADD;
                ip   = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                mins = burst_mins;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    clock_base = clock_base + 32'($urandom_range(0, 30));
                else if (r < 85)
                    clock_base = clock_base - 32'($urandom_range(0, 50));
                else if (r < 90)
                    clock_base = $urandom;
                cmd = ($urandom_range(0, 99) < 45) ? CMD_ADD : CMD_CHECK;
                if ($urandom_range(0, 99) < 85)
                    ip = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    ip = $urandom;
                r = $urandom_range(0, 99);
                if (r < 70)
                    mins = 16'($urandom_range(0, 3));
                else if (r < 90)
                    mins = 16'($urandom_range(0, 60));
                else
                    mins = 16'($urandom_range(0, 65535));
            end
            offer_item(cmd, ip, mins, clock_base);
        end
    endtask

    // long receiver hold-off
    initial
    begin
        hold_active = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                ban_table.check_result(banned, stored);
            out_stall <= hold_active || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        ban_table     = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_ADD;
        ip_address    = '0;
        ban_minutes   = '0;
        now_seconds   = '0;
        hold_go       = 1'b0;
        send_idle_pct = 32;
        recv_idle_pct = 65;
        clock_base    = '0;
        burst_left    = 0;
        burst_mins    = '0;
        addr_pool[0]  = 32'h0000_0000;
        addr_pool[1]  = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            addr_pool[i] = $urandom;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // zero-length ban, then pruning that survives a step back in time
        offer_item(CMD_ADD,   32'h0000_0000, 16'd0, 32'd100);
        offer_item(CMD_CHECK, 32'h0000_0000, 16'd0, 32'd100);
        offer_item(CMD_CHECK, 32'h0000_0000, 16'd0, 32'd101);
        offer_item(CMD_CHECK, 32'h0000_0000, 16'd0, 32'd50);
        // saturated expiry
        offer_item(CMD_ADD,   32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        offer_item(CMD_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        // duplicates fill the table, then one add is dropped
        for (int i = 0; i < TABLE_SIZE - 1; i++)
        begin
            offer_item(CMD_ADD, 32'h1234_5678, 16'hFFFF, 32'd0);
        end
        offer_item(CMD_ADD,   32'hA5A5_A5A5, 16'd1, 32'd0);
        offer_item(CMD_CHECK, 32'h1234_5678, 16'd0, 32'd0);
        offer_item(CMD_CHECK, 32'hA5A5_A5A5, 16'd0, 32'd0);

        offer_random(383, 40, 200);
        wait_drained();

        send_idle_pct = 65;
        recv_idle_pct = 32;
        offer_random(383, -1, -1);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        offer_random(384, -1, -1);
        wait_drained();

        repeat (2 * TABLE_SIZE + 8) @(posedge clk);
        if (ban_table.errors == 0 && ban_table.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ibt_pkg.sv
hw/rtl/ibt_mem.sv
hw/rtl/ibt_ctrl.sv
hw/rtl/ip_ban_table_with_expiry.sv
tb/tb_ip_ban_table_with_expiry.sv
